// ----- sv/itoar_pkg.sv -----
// Shared types, constants and the digit-to-ASCII map for the radix converter.
package itoar_pkg;

  localparam int unsigned RADIX_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [7:0] MINUS_CODE = 8'h2D;
  localparam logic [7:0] EMPTY_CODE = 8'h00;
  localparam logic [7:0] ZERO_CODE  = 8'h30;
  localparam logic [7:0] ALPHA_CODE = 8'h61;

  // dividend bits retired per divider cycle
  localparam int unsigned DIV_STEP_BITS = 8;

  // classification of one accepted item, travels with its magnitude
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               neg;
    logic               bad;
  } cls_t;

  // digit 0..35 to '0'-'9', 'a'-'z'
  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      return ZERO_CODE + d8;
    end
    return ALPHA_CODE + d8 - 8'd10;
  endfunction

endpackage

// ----- sv/integer_to_ascii_radix.sv -----
// Top level of the signed integer to ASCII converter, radix 2..36.
//
// Usage:
//  - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the 6-bit radix;
//    always ready. Reset value is 10. Write it only while the block is idle.
//  - in channel (in_valid_i/in_ready_o/value_i) takes one signed integer per item.
//    Items land in a two-entry queue, so up to two can be taken while the
//    back end is still converting or the receiver is stalled.
//  - out channel (out_valid_o/out_ready_i) gives one character per item:
//    '-' first for negatives, then digits most significant first, last_o on
//    the final one. A radix outside 2..36 gives one item with char_code_o 0,
//    last_o 1 and empty_res_o 1.
//  - Steps per input: a start in the idle state, then for each digit the divider
//    runs over the whole dividend, 8 remainder steps per cycle; then the minus
//    sign for a negative value; then each digit out of the digit stack RAM
//    (registered read), through a read state and a load state per digit.
//  - Receiver stall holds the output register; the back end waits and the
//    queue fills, after which in_ready_o drops.
//  - Reset clears the queue, the back-end state and the output valid.
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itoar_pkg::RADIX_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    char_code_o,
  output logic                          last_o,
  output logic                          empty_res_o
);

  localparam int unsigned QW = $bits(itoar_pkg::cls_t) + VALUE_BITS;

  itoar_pkg::cls_t       front_cls;
  logic [VALUE_BITS-1:0] front_mag;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  logic [QW-1:0]         q_rdata;
  itoar_pkg::cls_t       back_cls;
  logic [VALUE_BITS-1:0] back_mag;

  itoar_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .cls_o      (front_cls),
    .mag_o      (front_mag)
  );

  itoar_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({front_cls, front_mag}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  assign {back_cls, back_mag} = q_rdata;

  itoar_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .cls_i      (back_cls),
    .mag_i      (back_mag),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .empty_res_o(empty_res_o)
  );

  // empty result is a single zero character marked last
  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (char_code_o == itoar_pkg::EMPTY_CODE && last_o))
    else $error("empty result malformed");

  // the final character of a conversion is always a digit, never the sign
  a_last_not_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && !empty_res_o) |-> (char_code_o != itoar_pkg::MINUS_CODE))
    else $error("conversion ended on minus sign");

  // every regular character is a digit, a lower-case letter or the minus sign
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !empty_res_o) |->
      ((char_code_o >= 8'h30 && char_code_o <= 8'h39) ||
       (char_code_o >= 8'h61 && char_code_o <= 8'h7A) ||
       (char_code_o == itoar_pkg::MINUS_CODE)))
    else $error("character outside digit set");

  // the queue never takes an item while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("queue overflow");

endmodule

// ----- sv/itoar_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module itoar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/itoar_fifo.sv -----
// Two-entry queue between the classify front and the conversion back end.
module itoar_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = buf_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/itoar_front.sv -----
// Front end: radix register, input handshake, sign/magnitude split and radix check.
module itoar_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [itoar_pkg::RADIX_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output itoar_pkg::cls_t                     cls_o,
  output logic [VALUE_BITS-1:0]               mag_o
);

  logic [itoar_pkg::RADIX_W-1:0] radix_q;
  logic [VALUE_BITS-1:0]         raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;

  assign raw = $unsigned(value_i);

  always_comb begin
    cls_o.radix = radix_q;
    cls_o.neg   = raw[VALUE_BITS-1];
    cls_o.bad   = !(radix_q inside {[itoar_pkg::RADIX_MIN:itoar_pkg::RADIX_MAX]});
    // most negative value maps to 2^(N-1), which still fits unsigned
    mag_o       = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itoar_pkg::RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_data_i;
    end
  end

endmodule

// ----- sv/itoar_back.sv -----
// Back end: iterative digit divider, digit stack in RAM and reversed character emission.
module itoar_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  itoar_pkg::cls_t       cls_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            char_code_o,
  output logic                  last_o,
  output logic                  empty_res_o
);

  localparam int unsigned B   = itoar_pkg::DIV_STEP_BITS;
  localparam int unsigned RW  = itoar_pkg::RADIX_W;
  localparam int unsigned NCH = (VALUE_BITS + B - 1) / B;
  localparam int unsigned DW  = NCH * B;
  localparam int unsigned CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned AW  = $clog2(VALUE_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MINUS = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [CHW-1:0] chunk_q, chunk_d;
  logic [AW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [DW-1:0]  div_q, div_d;
  logic [RW-1:0]  rem_q, rem_d;
  logic           neg_q, neg_d;
  logic [RW-1:0]  radix_q, radix_d;

  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_char_q, out_char_d;
  logic           out_last_q, out_last_d;
  logic           out_empty_q, out_empty_d;

  logic [DW-1:0]  div_step;
  logic [RW-1:0]  rem_step;
  logic [RW:0]    trial;
  logic [B-1:0]   qbits;
  logic           chunk_last;
  logic           out_free;
  logic           out_load;
  logic           ram_we;
  logic [RW-1:0]  rd_digit;

  // B restoring-division steps on the 6-bit remainder per cycle
  always_comb begin
    rem_step = rem_q;
    qbits    = '0;
    trial    = '0;
    for (int i = 0; i < B; i++) begin
      trial = {rem_step, div_q[DW-1-i]};
      if (trial >= {1'b0, radix_q}) begin
        rem_step     = RW'(trial - {1'b0, radix_q});
        qbits[B-1-i] = 1'b1;
      end else begin
        rem_step = trial[RW-1:0];
      end
    end
    div_step = (div_q << B) | DW'(qbits);
  end

  assign chunk_last = (chunk_q == CHW'(NCH - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign ram_we     = (state_q == S_DIV) && chunk_last;
  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;

  itoar_ram #(
    .WIDTH(RW),
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q),
    .wdata_i(rem_step),
    .raddr_i(idx_q),
    .rdata_o(rd_digit)
  );

  always_comb begin
    state_d     = state_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    div_d       = div_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    out_load    = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          div_d   = DW'(mag_i);
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = '0;
          neg_d   = cls_i.neg;
          radix_d = cls_i.radix;
          state_d = cls_i.bad ? S_EMPTY : S_DIV;
        end
      end
      S_DIV: begin
        div_d = div_step;
        if (chunk_last) begin
          // remainder is the next digit; quotient becomes the new dividend
          rem_d   = '0;
          chunk_d = '0;
          cnt_d   = cnt_q + AW'(1);
          if (div_step == '0) begin
            idx_d   = cnt_q;
            state_d = neg_q ? S_MINUS : S_RD;
          end
        end else begin
          rem_d   = rem_step;
          chunk_d = chunk_q + CHW'(1);
        end
      end
      S_MINUS: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = itoar_pkg::MINUS_CODE;
          out_last_d  = 1'b0;
          out_empty_d = 1'b0;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = itoar_pkg::digit_char(rd_digit);
          out_last_d  = (idx_q == '0);
          out_empty_d = 1'b0;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_char_d  = itoar_pkg::EMPTY_CODE;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chunk_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q       <= div_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    radix_q     <= radix_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;

endmodule
